@@ rtl/eucm_pkg.sv @@
// Package for the EUCM projection unit: channel structs, register indexes,
// unit latencies and saturating helpers. No dependencies.
package eucm_pkg;

   typedef struct packed {
      logic              opcode;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic signed [31:0] pixel_u;
      logic signed [31:0] pixel_v;
      logic [30:0]        range_depth;
   } req_type;

   typedef struct packed {
      logic signed [31:0] image_u;
      logic signed [31:0] image_v;
      logic signed [31:0] ray_x;
      logic signed [31:0] ray_y;
      logic signed [31:0] ray_z;
      logic               degenerate;
   } rsp_type;

   typedef enum logic [2:0] {
      CSR_ALPHA    = 3'd0,
      CSR_BETA     = 3'd1,
      CSR_FOCAL_X  = 3'd2,
      CSR_FOCAL_Y  = 3'd3,
      CSR_CENTER_X = 3'd4,
      CSR_CENTER_Y = 3'd5
   } csr_index_type;

   localparam logic        OP_PROJECT = 1'b0;
   localparam int          DSTEPS     = 64;
   localparam int          SSTEPS     = 32;
   localparam int          LAT_MUL    = 3;
   localparam int          LAT_DIV    = DSTEPS + 2;
   localparam int          LAT_SQRT   = SSTEPS + 3;
   localparam logic signed [63:0] LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

   function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'(LIM)) return LIM;
      if (s < -65'(LIM)) return -LIM;
      return s[63:0];
   endfunction

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic [31:0] out32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

endpackage

@@ rtl/eucm_camera_project_unproject_unit.sv @@
// Top level of the EUCM projection unit: registers, both datapaths, output.
// Depends on eucm_pkg, eucm_mul, eucm_div, eucm_sqrt.
//
//  channel | ports                                       | transfer
//  --------+---------------------------------------------+----------------------
//  request | start, busy, req_item                       | start high, busy low
//  result  | rsp_valid, rsp_item                         | rsp_valid high, one cycle
//  config  | csr_valid, csr_ready, csr_index, csr_wdata  | csr_valid and csr_ready
//
// One item per cycle; busy stays low. Each result passes through the unproject
// chain of three dividers, two square roots and five multipliers, then the
// output register. Reset clears the valid chain and loads register defaults.
module eucm_camera_project_unproject_unit import eucm_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_item,
   output logic        rsp_valid,
   output rsp_type     rsp_item,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   localparam int LAT_P = 3 * LAT_MUL + LAT_SQRT + LAT_DIV;
   localparam int LAT_U = 3 * LAT_DIV + 5 * LAT_MUL + 2 * LAT_SQRT;
   localparam int PD    = LAT_U - LAT_P;
   localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

   typedef struct packed {
      logic               vld;
      logic               op;
      logic               deg;
      logic [30:0]        dep;
   } ctl_type;
   typedef struct packed {
      logic signed [63:0] zz, fxx, fyy, z;
   } p2_type;
   typedef struct packed {
      logic signed [63:0] fxx, fyy, z;
   } p3_type;
   typedef struct packed {
      logic signed [63:0] fxx, fyy;
   } p4_type;
   typedef struct packed {
      ctl_type            c;
      logic signed [63:0] r2, mxd, myd;
   } u3_type;
   typedef struct packed {
      ctl_type            c;
      logic signed [63:0] r2, mxd, myd, num;
   } u5_type;
   typedef struct packed {
      ctl_type            c;
      logic signed [63:0] mxd, myd, mzd;
   } u9_type;

   logic [16:0] alpha_ff;
   logic [23:0] beta_ff;
   logic [30:0] focal_x_ff, focal_y_ff;
   logic [31:0] center_x_ff, center_y_ff;
   logic signed [63:0] al, be, fx, fy, cx, cy, oma;

   assign al  = $signed({47'b0, alpha_ff});
   assign be  = $signed({40'b0, beta_ff});
   assign fx  = $signed({33'b0, focal_x_ff});
   assign fy  = $signed({33'b0, focal_y_ff});
   assign cx  = 64'(signed'(center_x_ff));
   assign cy  = 64'(signed'(center_y_ff));
   assign oma = ONE - al;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff    <= 17'd32768;
         beta_ff     <= 24'd65536;
         focal_x_ff  <= 31'd32768000;
         focal_y_ff  <= 31'd32768000;
         center_x_ff <= '0;
         center_y_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ALPHA:    alpha_ff    <= csr_wdata[16:0];
            CSR_BETA:     beta_ff     <= csr_wdata[23:0];
            CSR_FOCAL_X:  focal_x_ff  <= csr_wdata[30:0];
            CSR_FOCAL_Y:  focal_y_ff  <= csr_wdata[30:0];
            CSR_CENTER_X: center_x_ff <= csr_wdata;
            CSR_CENTER_Y: center_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic signed [63:0] px, py, pz, pu, pv;
   logic in_vld;
   assign in_vld = start && !busy;
   assign px    = 64'(req_item.point_x);
   assign py    = 64'(req_item.point_y);
   assign pz    = 64'(req_item.point_z);
   assign pu    = 64'(req_item.pixel_u);
   assign pv    = 64'(req_item.pixel_v);

   // project chain
   logic signed [63:0] pxx, pyy, pzz, pfx, pfy, p1z, pbr, pd, pad, pbz, pqu, pqv;
   p2_type p2t_i, p2t_o;
   p3_type p3t_i, p3t_o;
   p4_type p4t_o;
   logic   p5_den0;
   logic signed [63:0] pden;

   eucm_mul #(.FRAC_BITS(FRAC_BITS), .TW(64)) m_pxx (.clock, .reset, .a_i(px), .b_i(px),
      .tag_i(pz), .p_o(pxx), .tag_o(p1z));
   eucm_mul #(.FRAC_BITS(FRAC_BITS), .TW(1)) m_pyy (.clock, .reset, .a_i(py), .b_i(py),
      .tag_i(1'b0), .p_o(pyy), .tag_o());
   eucm_mul #(.FRAC_BITS(FRAC_BITS), .TW(1)) m_pzz (.clock, .reset, .a_i(pz), .b_i(pz),
      .tag_i(1'b0), .p_o(pzz), .tag_o());
   eucm_mul #(.FRAC_BITS(FRAC_BITS), .TW(1)) m_pfx (.clock, .reset, .a_i(fx), .b_i(px),
      .tag_i(1'b0), .p_o(pfx), .tag_o());
   eucm_mul #(.FRAC_BITS(FRAC_BITS), .TW(1)) m_pfy (.clock, .reset, .a_i(fy), .b_i(py),
      .tag_i(1'b0), .p_o(pfy), .tag_o());

   assign p2t_i = '{zz: pzz, fxx: pfx, fyy: pfy, z: p1z};
   eucm_mul #(.FRAC_BITS(FRAC_BITS), .TW($bits(p2_type))) m_pbr (.clock, .reset,
      .a_i(be), .b_i(sadd(pxx, pyy)), .tag_i(p2t_i), .p_o(pbr), .tag_o(p2t_o));

   assign p3t_i = '{fxx: p2t_o.fxx, fyy: p2t_o.fyy, z: p2t_o.z};
   eucm_sqrt #(.FRAC_BITS(FRAC_BITS), .TW($bits(p3_type))) s_pd (.clock, .reset,
      .a_i(sadd(pbr, p2t_o.zz)), .tag_i(p3t_i), .r_o(pd), .tag_o(p3t_o));

   eucm_mul #(.FRAC_BITS(FRAC_BITS), .TW($bits(p4_type))) m_pad (.clock, .reset,
      .a_i(al), .b_i(pd), .tag_i(p4_type'({p3t_o.fxx, p3t_o.fyy})), .p_o(pad),
      .tag_o(p4t_o));
   eucm_mul #(.FRAC_BITS(FRAC_BITS), .TW(1)) m_pbz (.clock, .reset, .a_i(oma),
      .b_i(p3t_o.z), .tag_i(1'b0), .p_o(pbz), .tag_o());

   assign pden = sadd(pad, pbz);
   eucm_div #(.FRAC_BITS(FRAC_BITS), .TW(1)) d_pu (.clock, .reset, .n_i(p4t_o.fxx),
      .d_i(pden), .tag_i(pden == 64'sd0), .q_o(pqu), .tag_o(p5_den0));
   eucm_div #(.FRAC_BITS(FRAC_BITS), .TW(1)) d_pv (.clock, .reset, .n_i(p4t_o.fyy),
      .d_i(pden), .tag_i(1'b0), .q_o(pqv), .tag_o());

   logic [64:0] pres;
   logic [64:0] pd_ff [0:PD-1];
   assign pres = p5_den0 ? {1'b1, 64'd0}
                         : {1'b0, out32(sadd(pqu, cx)), out32(sadd(pqv, cy))};

   always_ff @(posedge clock) begin
      pd_ff[0] <= pres;
      for (int i = 1; i < PD; i++) pd_ff[i] <= pd_ff[i-1];
   end

   // unproject chain
   ctl_type c0, c1, c2;
   logic signed [63:0] umx, umy, uxx, uyy, uaa, uxd, uyd, ut1, ut2, um1, um2;
   logic signed [63:0] usq, uas, uden, umz, uzz, uzd, un, uqx, uqy, uqz;
   u3_type u3t_i, u3t_o, u4t_o, u7t_i, u7t_o, u8t_o;
   u5_type u5t_i, u5t_o, u6t_o;
   u9_type u9t_i, u9t_o;
   ctl_type u10_i, u10_o;

   assign c0 = '{vld: in_vld, op: req_item.opcode,
                 deg: (focal_x_ff == 31'd0) || (focal_y_ff == 31'd0),
                 dep: req_item.range_depth};

   eucm_div #(.FRAC_BITS(FRAC_BITS), .TW($bits(ctl_type))) d_mx (.clock, .reset,
      .n_i(sadd(pu, -cx)), .d_i(fx), .tag_i(c0), .q_o(umx), .tag_o(c1));
   eucm_div #(.FRAC_BITS(FRAC_BITS), .TW(1)) d_my (.clock, .reset,
      .n_i(sadd(pv, -cy)), .d_i(fy), .tag_i(1'b0), .q_o(umy), .tag_o());

   // depth rides alongside from the request through the first divider
   logic signed [63:0] dep_c1;
   assign dep_c1 = $signed({33'b0, c1.dep});

   eucm_mul #(.FRAC_BITS(FRAC_BITS), .TW($bits(ctl_type))) m_uxx (.clock, .reset,
      .a_i(umx), .b_i(umx), .tag_i(c1), .p_o(uxx), .tag_o(c2));
   eucm_mul #(.FRAC_BITS(FRAC_BITS), .TW(1)) m_uyy (.clock, .reset, .a_i(umy),
      .b_i(umy), .tag_i(1'b0), .p_o(uyy), .tag_o());
   eucm_mul #(.FRAC_BITS(FRAC_BITS), .TW(1)) m_uaa (.clock, .reset, .a_i(al),
      .b_i(al), .tag_i(1'b0), .p_o(uaa), .tag_o());
   eucm_mul #(.FRAC_BITS(FRAC_BITS), .TW(1)) m_uxd (.clock, .reset, .a_i(umx),
      .b_i(dep_c1), .tag_i(1'b0), .p_o(uxd), .tag_o());
   eucm_mul #(.FRAC_BITS(FRAC_BITS), .TW(1)) m_uyd (.clock, .reset, .a_i(umy),
      .b_i(dep_c1), .tag_i(1'b0), .p_o(uyd), .tag_o());

   assign u3t_i = '{c: c2, r2: sadd(uxx, uyy), mxd: uxd, myd: uyd};
   eucm_mul #(.FRAC_BITS(FRAC_BITS), .TW($bits(u3_type))) m_ut1 (.clock, .reset,
      .a_i(uaa), .b_i(be), .tag_i(u3t_i), .p_o(ut1), .tag_o(u3t_o));
   eucm_mul #(.FRAC_BITS(FRAC_BITS), .TW(1)) m_ut2 (.clock, .reset,
      .a_i(sadd(al <<< 1, -ONE)), .b_i(be), .tag_i(1'b0), .p_o(ut2), .tag_o());

   eucm_mul #(.FRAC_BITS(FRAC_BITS), .TW($bits(u3_type))) m_um1 (.clock, .reset,
      .a_i(ut1), .b_i(u3t_o.r2), .tag_i(u3t_o), .p_o(um1), .tag_o(u4t_o));
   eucm_mul #(.FRAC_BITS(FRAC_BITS), .TW(1)) m_um2 (.clock, .reset, .a_i(ut2),
      .b_i(u3t_o.r2), .tag_i(1'b0), .p_o(um2), .tag_o());

   assign u5t_i = '{c: u4t_o.c, r2: u4t_o.r2, mxd: u4t_o.mxd, myd: u4t_o.myd,
                    num: sadd(ONE, -um1)};
   eucm_sqrt #(.FRAC_BITS(FRAC_BITS), .TW($bits(u5_type))) s_arg (.clock, .reset,
      .a_i(sadd(ONE, -um2)), .tag_i(u5t_i), .r_o(usq), .tag_o(u5t_o));

   eucm_mul #(.FRAC_BITS(FRAC_BITS), .TW($bits(u5_type))) m_uas (.clock, .reset,
      .a_i(al), .b_i(usq), .tag_i(u5t_o), .p_o(uas), .tag_o(u6t_o));

   always_comb begin
      uden        = sadd(uas, oma);
      u7t_i.c     = u6t_o.c;
      u7t_i.c.deg = u6t_o.c.deg || (uden == 64'sd0);
      u7t_i.r2    = u6t_o.r2;
      u7t_i.mxd   = u6t_o.mxd;
      u7t_i.myd   = u6t_o.myd;
   end
   eucm_div #(.FRAC_BITS(FRAC_BITS), .TW($bits(u3_type))) d_mz (.clock, .reset,
      .n_i(u6t_o.num), .d_i(uden), .tag_i(u7t_i), .q_o(umz), .tag_o(u7t_o));

   eucm_mul #(.FRAC_BITS(FRAC_BITS), .TW($bits(u3_type))) m_uzz (.clock, .reset,
      .a_i(umz), .b_i(umz), .tag_i(u7t_o), .p_o(uzz), .tag_o(u8t_o));
   eucm_mul #(.FRAC_BITS(FRAC_BITS), .TW(1)) m_uzd (.clock, .reset, .a_i(umz),
      .b_i($signed({33'b0, u7t_o.c.dep})), .tag_i(1'b0), .p_o(uzd), .tag_o());

   assign u9t_i = '{c: u8t_o.c, mxd: u8t_o.mxd, myd: u8t_o.myd, mzd: uzd};
   eucm_sqrt #(.FRAC_BITS(FRAC_BITS), .TW($bits(u9_type))) s_n (.clock, .reset,
      .a_i(sadd(u8t_o.r2, uzz)), .tag_i(u9t_i), .r_o(un), .tag_o(u9t_o));

   always_comb begin
      u10_i     = u9t_o.c;
      u10_i.deg = u9t_o.c.deg || (un == 64'sd0);
   end
   eucm_div #(.FRAC_BITS(FRAC_BITS), .TW($bits(ctl_type))) d_qx (.clock, .reset,
      .n_i(u9t_o.mxd), .d_i(un), .tag_i(u10_i), .q_o(uqx), .tag_o(u10_o));
   eucm_div #(.FRAC_BITS(FRAC_BITS), .TW(1)) d_qy (.clock, .reset,
      .n_i(u9t_o.myd), .d_i(un), .tag_i(1'b0), .q_o(uqy), .tag_o());
   eucm_div #(.FRAC_BITS(FRAC_BITS), .TW(1)) d_qz (.clock, .reset,
      .n_i(u9t_o.mzd), .d_i(un), .tag_i(1'b0), .q_o(uqz), .tag_o());

   // output register
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff;

   always_comb begin
      rsp_in = '0;
      if (u10_o.op == OP_PROJECT) begin
         rsp_in.degenerate = pd_ff[PD-1][64];
         rsp_in.image_u    = pd_ff[PD-1][63:32];
         rsp_in.image_v    = pd_ff[PD-1][31:0];
      end else if (u10_o.deg) begin
         rsp_in.degenerate = 1'b1;
      end else begin
         rsp_in.ray_x = out32(uqx);
         rsp_in.ray_y = out32(uqy);
         rsp_in.ray_z = out32(uqz);
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= u10_o.vld;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
endmodule

@@ rtl/eucm_mul.sv @@
// Pipelined saturating fixed-point multiplier, 32x32 partial products.
// Depends on eucm_pkg.
module eucm_mul import eucm_pkg::*; #(
   parameter int FRAC_BITS = 16,
   parameter int TW = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic signed [63:0] a_i,
   input  logic signed [63:0] b_i,
   input  logic [TW-1:0]      tag_i,
   output logic signed [63:0] p_o,
   output logic [TW-1:0]      tag_o
);
   logic [63:0] ma_ff, mb_ff;
   logic        neg1_ff, neg2_ff, neg3_ff;
   logic [63:0] hh_ff, hl_ff, lh_ff, ll_ff;
   logic [TW-1:0] tag1_ff, tag2_ff, tag3_ff;
   logic signed [63:0] p_ff, p_in;
   logic [64:0] mid;
   logic [96:0] full;
   logic [63:0] sh, m;

   always_comb begin
      mid  = {1'b0, hl_ff} + {1'b0, lh_ff};
      full = {mid, 32'b0} + {33'b0, ll_ff};
      sh   = full[63:0] >> FRAC_BITS;
      if (hh_ff != 64'd0 || full[96:64] != 33'd0 || sh > 64'(LIM)) begin
         m = 64'(LIM);
      end else begin
         m = sh;
      end
      p_in = neg2_ff ? -$signed(m) : $signed(m);
   end

   always_ff @(posedge clock) begin
      ma_ff   <= mag64(a_i);
      mb_ff   <= mag64(b_i);
      neg1_ff <= (a_i < 0) != (b_i < 0);
      hh_ff   <= 64'(ma_ff[63:32]) * 64'(mb_ff[63:32]);
      hl_ff   <= 64'(ma_ff[63:32]) * 64'(mb_ff[31:0]);
      lh_ff   <= 64'(ma_ff[31:0]) * 64'(mb_ff[63:32]);
      ll_ff   <= 64'(ma_ff[31:0]) * 64'(mb_ff[31:0]);
      neg2_ff <= neg1_ff;
      neg3_ff <= neg2_ff;
      p_ff    <= p_in;
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else begin
         tag1_ff <= tag_i;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
   end

   assign p_o   = neg3_ff ? p_ff : p_ff;
   assign tag_o = tag3_ff;
endmodule

@@ rtl/eucm_div.sv @@
// Pipelined saturating fixed-point divider, one quotient bit per stage.
// Depends on eucm_pkg.
module eucm_div import eucm_pkg::*; #(
   parameter int FRAC_BITS = 16,
   parameter int TW = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic signed [63:0] n_i,
   input  logic signed [63:0] d_i,
   input  logic [TW-1:0]      tag_i,
   output logic signed [63:0] q_o,
   output logic [TW-1:0]      tag_o
);
   localparam logic [63:0] NMAX = 64'hFFFF_FFFF_FFFF_FFFF >> FRAC_BITS;

   logic [63:0] num_ff [0:DSTEPS];
   logic [63:0] rem_ff [0:DSTEPS];
   logic [63:0] quo_ff [0:DSTEPS];
   logic [63:0] md_ff  [0:DSTEPS];
   logic        neg_ff [0:DSTEPS];
   logic        zr_ff  [0:DSTEPS];
   logic        ov_ff  [0:DSTEPS];
   logic [TW-1:0] tag_ff [0:DSTEPS];
   logic [63:0] num_in [1:DSTEPS];
   logic [63:0] rem_in [1:DSTEPS];
   logic [63:0] quo_in [1:DSTEPS];
   logic signed [63:0] q_ff, q_in;
   logic [TW-1:0] tago_ff;
   logic [64:0] trial;
   logic [63:0] mn, qm;

   assign mn = mag64(n_i);

   always_comb begin
      trial = '0;
      for (int s = 1; s <= DSTEPS; s++) begin
         trial = {rem_ff[s-1], num_ff[s-1][63]};
         if (trial >= {1'b0, md_ff[s-1]}) begin
            rem_in[s] = 64'(trial - {1'b0, md_ff[s-1]});
            quo_in[s] = {quo_ff[s-1][62:0], 1'b1};
         end else begin
            rem_in[s] = trial[63:0];
            quo_in[s] = {quo_ff[s-1][62:0], 1'b0};
         end
         num_in[s] = {num_ff[s-1][62:0], 1'b0};
      end
      qm = (quo_ff[DSTEPS] > 64'(LIM)) ? 64'(LIM) : quo_ff[DSTEPS];
      if (zr_ff[DSTEPS]) begin
         q_in = '0;
      end else if (ov_ff[DSTEPS]) begin
         q_in = neg_ff[DSTEPS] ? -LIM : LIM;
      end else begin
         q_in = neg_ff[DSTEPS] ? -$signed(qm) : $signed(qm);
      end
   end

   always_ff @(posedge clock) begin
      num_ff[0] <= mn << FRAC_BITS;
      rem_ff[0] <= '0;
      quo_ff[0] <= '0;
      md_ff[0]  <= mag64(d_i);
      neg_ff[0] <= (n_i < 0) != (d_i < 0);
      zr_ff[0]  <= (d_i == 64'sd0);
      ov_ff[0]  <= (mn > NMAX);
      for (int s = 1; s <= DSTEPS; s++) begin
         num_ff[s] <= num_in[s];
         rem_ff[s] <= rem_in[s];
         quo_ff[s] <= quo_in[s];
         md_ff[s]  <= md_ff[s-1];
         neg_ff[s] <= neg_ff[s-1];
         zr_ff[s]  <= zr_ff[s-1];
         ov_ff[s]  <= ov_ff[s-1];
      end
      q_ff <= q_in;
      if (reset) begin
         for (int s = 0; s <= DSTEPS; s++) tag_ff[s] <= '0;
         tago_ff <= '0;
      end else begin
         tag_ff[0] <= tag_i;
         for (int s = 1; s <= DSTEPS; s++) tag_ff[s] <= tag_ff[s-1];
         tago_ff <= tag_ff[DSTEPS];
      end
   end

   assign q_o   = q_ff;
   assign tag_o = tago_ff;
endmodule

@@ rtl/eucm_sqrt.sv @@
// Pipelined fixed-point square root with range prescale, two bits per stage.
// Depends on eucm_pkg.
module eucm_sqrt import eucm_pkg::*; #(
   parameter int FRAC_BITS = 16,
   parameter int TW = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic signed [63:0] a_i,
   input  logic [TW-1:0]      tag_i,
   output logic signed [63:0] r_o,
   output logic [TW-1:0]      tag_o
);
   localparam logic [63:0] AMAX = 64'hFFFF_FFFF_FFFF_FFFF >> FRAC_BITS;

   logic signed [63:0] a_ff;
   logic [TW-1:0] taga_ff, tago_ff;
   logic [63:0] op_ff  [0:SSTEPS];
   logic [35:0] rem_ff [0:SSTEPS];
   logic [31:0] rt_ff  [0:SSTEPS];
   logic [3:0]  k_ff   [0:SSTEPS];
   logic [TW-1:0] tag_ff [0:SSTEPS];
   logic [35:0] rem_in [1:SSTEPS];
   logic [31:0] rt_in  [1:SSTEPS];
   logic [35:0] acc, trial;
   logic [3:0]  k;
   logic [63:0] ua, op_in;
   logic signed [63:0] r_ff;

   always_comb begin
      ua = 64'(a_ff);
      k  = '0;
      for (int kk = 15; kk >= 0; kk--) begin
         if ((ua >> (2 * kk)) <= AMAX) k = 4'(kk);
      end
      op_in = (a_ff > 64'sd0) ? ((ua >> (2 * k)) << FRAC_BITS) : 64'd0;
      acc   = '0;
      trial = '0;
      for (int s = 1; s <= SSTEPS; s++) begin
         acc   = {rem_ff[s-1][33:0], op_ff[s-1][63:62]};
         trial = {2'b00, rt_ff[s-1], 2'b01};
         if (acc >= trial) begin
            rem_in[s] = acc - trial;
            rt_in[s]  = {rt_ff[s-1][30:0], 1'b1};
         end else begin
            rem_in[s] = acc;
            rt_in[s]  = {rt_ff[s-1][30:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_i;
      op_ff[0]  <= op_in;
      rem_ff[0] <= '0;
      rt_ff[0]  <= '0;
      k_ff[0]   <= k;
      for (int s = 1; s <= SSTEPS; s++) begin
         op_ff[s]  <= {op_ff[s-1][61:0], 2'b00};
         rem_ff[s] <= rem_in[s];
         rt_ff[s]  <= rt_in[s];
         k_ff[s]   <= k_ff[s-1];
      end
      r_ff <= $signed(64'(rt_ff[SSTEPS]) << k_ff[SSTEPS]);
      if (reset) begin
         taga_ff <= '0;
         for (int s = 0; s <= SSTEPS; s++) tag_ff[s] <= '0;
         tago_ff <= '0;
      end else begin
         taga_ff   <= tag_i;
         tag_ff[0] <= taga_ff;
         for (int s = 1; s <= SSTEPS; s++) tag_ff[s] <= tag_ff[s-1];
         tago_ff <= tag_ff[SSTEPS];
      end
   end

   assign r_o   = r_ff;
   assign tag_o = tago_ff;
endmodule

@@ tb/sv/eucm_camera_project_unproject_unit_tb.sv @@
// Testbench for the EUCM project/unproject unit: directed table, zero-focal rows,
// then random items against a fixed-point predictor. Depends on eucm_pkg and the unit RTL.
module eucm_camera_project_unproject_unit_tb;
   import eucm_pkg::*;

   localparam int LATENCY   = 284;
   localparam int CYCLE_CAP = 400000;
   localparam int N_RANDOM  = 1100;
   localparam logic OP_UNPROJECT = 1'b1;
   localparam logic signed [63:0] ONE = 64'sd65536;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_item = '0;
   logic        rsp_valid;
   rsp_type     rsp_item;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   eucm_camera_project_unproject_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   logic [16:0] alpha_reg;
   logic [23:0] beta_reg;
   logic [30:0] fx_reg, fy_reg;
   logic signed [31:0] cx_reg, cy_reg;

   rsp_type expected_rsp_q[$];
   int      fail_count = 0;
   int      cycle_count = 0;

   typedef struct {
      req_type item;
      logic    has_known;
      rsp_type known;
   } stim_row_type;

   function automatic logic signed [63:0] fx_mag_to_signed(logic [63:0] m, logic neg);
      logic signed [63:0] v;
      v = (m > 64'(LIM)) ? LIM : $signed(m);
      return neg ? -v : v;
   endfunction

   function automatic logic signed [63:0] fx_mul(logic signed [63:0] a,
                                                 logic signed [63:0] b);
      logic [127:0] p;
      p = 128'(mag64(a)) * 128'(mag64(b));
      if (p[127:64] != 0) return fx_mag_to_signed(64'hFFFF_FFFF_FFFF_FFFF, (a < 0) != (b < 0));
      return fx_mag_to_signed(p[63:0] >> 16, (a < 0) != (b < 0));
   endfunction

   function automatic logic signed [63:0] fx_div(logic signed [63:0] n,
                                                 logic signed [63:0] d);
      logic [63:0] mn, md;
      mn = mag64(n);
      md = mag64(d);
      if (md == 0) return 0;
      if (mn > (64'hFFFF_FFFF_FFFF_FFFF >> 16))
         return fx_mag_to_signed(64'hFFFF_FFFF_FFFF_FFFF, (n < 0) != (d < 0));
      return fx_mag_to_signed((mn << 16) / md, (n < 0) != (d < 0));
   endfunction

   function automatic logic [63:0] int_root(logic [63:0] a);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > a) b = b >> 2;
      while (b != 0) begin
         if (a >= r + b) begin
            a = a - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic signed [63:0] fx_sqrt(logic signed [63:0] a);
      logic [63:0] ua;
      int k;
      if (a <= 0) return 0;
      ua = a;
      k = 0;
      while ((ua >> (2 * k)) > (64'hFFFF_FFFF_FFFF_FFFF >> 16)) k++;
      return fx_mag_to_signed(int_root((ua >> (2 * k)) << 16) << k, 1'b0);
   endfunction

   function automatic rsp_type predict_camera(req_type q);
      rsp_type o;
      logic signed [63:0] al, be, fx, fy, cx, cy, x, y, z, r, d, den;
      logic signed [63:0] mx, my, r2, num, arg, mz, n, dep;
      o = '0;
      al = alpha_reg; be = beta_reg; fx = fx_reg; fy = fy_reg;
      cx = cx_reg; cy = cy_reg;
      if (q.opcode == OP_PROJECT) begin
         x = q.point_x; y = q.point_y; z = q.point_z;
         r = sadd(fx_mul(x, x), fx_mul(y, y));
         d = fx_sqrt(sadd(fx_mul(be, r), fx_mul(z, z)));
         den = sadd(fx_mul(al, d), fx_mul(ONE - al, z));
         if (den == 0) begin
            o.degenerate = 1'b1;
            return o;
         end
         o.image_u = out32(sadd(fx_div(fx_mul(fx, x), den), cx));
         o.image_v = out32(sadd(fx_div(fx_mul(fy, y), den), cy));
         return o;
      end
      if (fx == 0 || fy == 0) begin
         o.degenerate = 1'b1;
         return o;
      end
      dep = q.range_depth;
      mx = fx_div(sadd(q.pixel_u, -cx), fx);
      my = fx_div(sadd(q.pixel_v, -cy), fy);
      r2 = sadd(fx_mul(mx, mx), fx_mul(my, my));
      num = sadd(ONE, -fx_mul(fx_mul(fx_mul(al, al), be), r2));
      arg = sadd(ONE, -fx_mul(fx_mul(sadd(2 * al, -ONE), be), r2));
      den = sadd(fx_mul(al, fx_sqrt(arg)), ONE - al);
      if (den == 0) begin
         o.degenerate = 1'b1;
         return o;
      end
      mz = fx_div(num, den);
      n = fx_sqrt(sadd(r2, fx_mul(mz, mz)));
      if (n == 0) begin
         o.degenerate = 1'b1;
         return o;
      end
      o.ray_x = out32(fx_div(fx_mul(mx, dep), n));
      o.ray_y = out32(fx_div(fx_mul(my, dep), n));
      o.ray_z = out32(fx_div(fx_mul(mz, dep), n));
      return o;
   endfunction

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n != 0) start <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic send_request(req_type q, logic has_known, rsp_type known);
      rsp_type p;
      p = predict_camera(q);
      if (has_known && p !== known) begin
         $error("directed row disagrees with predictor: exp %h got %h", known, p);
         fail_count++;
      end
      start <= 1'b1;
      req_item <= q;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_rsp_q.push_back(p);
      @(negedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_ALPHA:    alpha_reg = value[16:0];
         CSR_BETA:     beta_reg = value[23:0];
         CSR_FOCAL_X:  fx_reg = value[30:0];
         CSR_FOCAL_Y:  fy_reg = value[30:0];
         CSR_CENTER_X: cx_reg = value;
         CSR_CENTER_Y: cy_reg = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (expected_rsp_q.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   function automatic logic signed [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
         2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         3: return 32'sd0;
         default: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
      endcase
   endfunction

   function automatic req_type random_request();
      req_type q;
      q.opcode = $urandom_range(0, 1);
      q.point_x = pick_coord();
      q.point_y = pick_coord();
      q.point_z = ($urandom_range(0, 2) != 0) ? $signed($urandom_range(1, 32'h0400_0000))
                                               : pick_coord();
      q.pixel_u = pick_coord();
      q.pixel_v = pick_coord();
      q.range_depth = ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                  : 31'($urandom_range(0, 32'h0100_0000));
      return q;
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         if (expected_rsp_q.size() == 0) begin
            $error("result with none expected: %h", rsp_item);
            fail_count++;
         end else begin
            e = expected_rsp_q.pop_front();
            if (rsp_item.image_u !== e.image_u) begin
               $error("image_u exp %h got %h", e.image_u, rsp_item.image_u); fail_count++;
            end
            if (rsp_item.image_v !== e.image_v) begin
               $error("image_v exp %h got %h", e.image_v, rsp_item.image_v); fail_count++;
            end
            if (rsp_item.ray_x !== e.ray_x) begin
               $error("ray_x exp %h got %h", e.ray_x, rsp_item.ray_x); fail_count++;
            end
            if (rsp_item.ray_y !== e.ray_y) begin
               $error("ray_y exp %h got %h", e.ray_y, rsp_item.ray_y); fail_count++;
            end
            if (rsp_item.ray_z !== e.ray_z) begin
               $error("ray_z exp %h got %h", e.ray_z, rsp_item.ray_z); fail_count++;
            end
            if (rsp_item.degenerate !== e.degenerate) begin
               $error("degenerate exp %b got %b", e.degenerate, rsp_item.degenerate);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("FAIL eucm_camera_project_unproject_unit");
         $finish;
      end
   end

   stim_row_type stim_table[$];

   function automatic stim_row_type make_row(logic op, logic signed [31:0] a,
                                             logic signed [31:0] b, logic signed [31:0] c,
                                             logic [30:0] dep, logic has_known);
      stim_row_type s;
      s.item.opcode = op;
      s.item.point_x = a; s.item.point_y = b; s.item.point_z = c;
      s.item.pixel_u = a; s.item.pixel_v = b; s.item.range_depth = dep;
      s.has_known = has_known;
      s.known = '0;
      if (has_known) s.known.degenerate = 1'b1;
      return s;
   endfunction

   initial begin
      rsp_type none;
      stim_row_type row, deg_row;
      none = '0;
      alpha_reg = 17'd32768; beta_reg = 24'd65536;
      fx_reg = 31'd32768000; fy_reg = 31'd32768000;
      cx_reg = 0; cy_reg = 0;
      // origin projects to a zero denominator
      stim_table.push_back(make_row(OP_PROJECT, 0, 0, 0, 0, 1'b1));
      stim_table.push_back(make_row(OP_PROJECT, 0, 0, 32'sh0001_0000, 0, 1'b0));
      stim_table.push_back(make_row(OP_PROJECT, 32'sh0001_0000, -32'sh0002_0000,
                                    32'sh0004_0000, 0, 1'b0));
      stim_table.push_back(make_row(OP_PROJECT, 32'sh7FFF_FFFF, 32'sh8000_0000,
                                    32'sh7FFF_FFFF, 0, 1'b0));
      stim_table.push_back(make_row(OP_PROJECT, 32'sh8000_0000, 32'sh7FFF_FFFF,
                                    32'sh8000_0000, 0, 1'b0));
      stim_table.push_back(make_row(OP_PROJECT, 32'sh0000_0001, -32'sh0000_0001,
                                    -32'sh0001_0000, 0, 1'b0));
      stim_table.push_back(make_row(OP_UNPROJECT, 0, 0, 0, 31'h7FFF_FFFF, 1'b0));
      stim_table.push_back(make_row(OP_UNPROJECT, 0, 0, 0, 0, 1'b0));
      stim_table.push_back(make_row(OP_UNPROJECT, 32'sh7FFF_FFFF, 32'sh8000_0000, 0,
                                    31'h7FFF_FFFF, 1'b0));
      stim_table.push_back(make_row(OP_UNPROJECT, 32'sh00C8_0000, -32'sh0064_0000, 0,
                                    31'h000A_0000, 1'b0));
      stim_table.push_back(make_row(OP_UNPROJECT, 32'sh8000_0000, 32'sh7FFF_FFFF, 0,
                                    31'h0001_0000, 1'b0));
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (stim_table[i]) begin
         send_request(stim_table[i].item, stim_table[i].has_known, stim_table[i].known);
         idle_gap();
      end
      drain();
      // zero focal length makes every unproject degenerate
      write_register(CSR_FOCAL_X, 32'd0);
      for (int i = 0; i < 3; i++) begin
         row = make_row(OP_UNPROJECT, 32'sh0010_0000 * i, 32'sh0002_0000, 0,
                        31'h0001_0000, 1'b0);
         deg_row = make_row(OP_UNPROJECT, 0, 0, 0, 0, 1'b1);
         send_request(row.item, 1'b1, deg_row.known);
      end
      row = make_row(OP_PROJECT, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 0, 1'b0);
      send_request(row.item, 1'b0, none);
      drain();
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_register(CSR_ALPHA, 32'd0); write_register(CSR_BETA, 32'd0);
               write_register(CSR_FOCAL_X, 32'h7FFF_FFFF);
               write_register(CSR_FOCAL_Y, 32'd1);
               write_register(CSR_CENTER_X, 32'h8000_0000);
               write_register(CSR_CENTER_Y, 32'h7FFF_FFFF);
            end
            1: begin
               write_register(CSR_ALPHA, 32'd65536);
               write_register(CSR_BETA, 32'hFF_FFFF);
               write_register(CSR_FOCAL_X, 32'd32768000);
               write_register(CSR_FOCAL_Y, 32'd16384000);
               write_register(CSR_CENTER_X, 32'h0140_0000);
               write_register(CSR_CENTER_Y, 32'h00F0_0000);
            end
            2: begin
               // alpha above one: 1-alpha goes negative
               write_register(CSR_ALPHA, 32'h1_FFFF);
               write_register(CSR_BETA, 32'd65536);
               write_register(CSR_CENTER_X, 32'd0);
            end
            3: begin
               write_register(CSR_ALPHA, $urandom_range(0, 32'h1_FFFF));
               write_register(CSR_BETA, $urandom_range(0, 32'hFF_FFFF));
               write_register(CSR_FOCAL_X, $urandom_range(1, 32'h7FFF_FFFF));
               write_register(CSR_FOCAL_Y, $urandom_range(1, 32'h7FFF_FFFF));
               write_register(CSR_CENTER_X, $urandom);
               write_register(CSR_CENTER_Y, $urandom);
            end
            4: begin
               write_register(CSR_ALPHA, 32'd39321);
               write_register(CSR_BETA, 32'd72089);
               write_register(CSR_FOCAL_X, 32'd29491200);
               write_register(CSR_FOCAL_Y, 32'd29491200);
               write_register(CSR_CENTER_X, 32'h0140_0000);
               write_register(CSR_CENTER_Y, 32'h00F0_0000);
            end
            default: begin
               write_register(CSR_ALPHA, 32'd32768);
               write_register(CSR_FOCAL_Y, 32'd0);
            end
         endcase
         for (int i = 0; i < N_RANDOM / 6; i++) begin
            send_request(random_request(), 1'b0, none);
            if ($urandom_range(0, 1) == 0) idle_gap();
            if (i == 40) begin
               start <= 1'b0;
               while (expected_rsp_q.size() != 0) @(negedge clock);
            end
         end
         drain();
      end
      if (fail_count == 0) begin
         $display("PASS eucm_camera_project_unproject_unit");
      end else begin
         $display("FAIL eucm_camera_project_unproject_unit");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/eucm_pkg.sv
rtl/eucm_mul.sv
rtl/eucm_div.sv
rtl/eucm_sqrt.sv
rtl/eucm_camera_project_unproject_unit.sv
tb/sv/eucm_camera_project_unproject_unit_tb.sv
